// ----- hw/rtl/prn_pkg.sv -----
// ----------------------------------------------------------------------------
// prn_pkg: pitch ratio normalizer shared definitions
// Widths, sizing constants, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package prn_pkg;

    // sizing
    localparam int TERM_WIDTH    = 16;
    localparam int LOG_FRAC_BITS = 16;

    // port field widths (fixed by the stream format)
    localparam int TOP_IN_W  = 16;
    localparam int BOT_IN_W  = 16;
    localparam int OCT_IN_W  = 10;
    localparam int RED_W     = 32;
    localparam int OCT_W     = 11;
    localparam int LOG_W     = 16;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 96;

    // input term bits actually used
    localparam int IN_W   = (TERM_WIDTH < TOP_IN_W) ? TERM_WIDTH : TOP_IN_W;
    // normalized terms stay below twice the input range
    localparam int WORK_W = IN_W + 1;
    // count of common factors of two in the GCD
    localparam int K_W    = $clog2(WORK_W);

    // shift-in bits of the divider, Q1.31 log operand
    localparam int DIV_BITS = 32;
    localparam int Y_W      = 32;
    localparam int PROD_W   = 2 * Y_W;
    localparam int CNT_W    = 5;

    // log bit collector, never narrower than the output field
    localparam int LOGB_W = (LOG_FRAC_BITS > LOG_W) ? LOG_FRAC_BITS : LOG_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM_UP,
        ST_NORM_DN,
        ST_GCD,
        ST_DIV_N,
        ST_START_D,
        ST_DIV_D,
        ST_START_L,
        ST_DIV_L,
        ST_LOG_INIT,
        ST_LOG_SQ,
        ST_LOG_UPD,
        ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_NORM_UP,
        CMD_NORM_DN,
        CMD_GCD_LOAD,
        CMD_GCD_STEP,
        CMD_DIV_N_START,
        CMD_DIV_STEP,
        CMD_DIV_D_START,
        CMD_DIV_L_START,
        CMD_LOG_INIT,
        CMD_LOG_MUL,
        CMD_LOG_UPD,
        CMD_OUT_LOAD
    } t_cmd;

    typedef struct packed {
        logic in_null;   // incoming item has a zero term
        logic num_lt;    // num < den
        logic num_ge2;   // num >= 2*den
        logic gcd_eq;    // GCD operands have met
    } t_status;

endpackage

// ----- hw/rtl/pitch_ratio_normalizer_unit.sv -----
// Sequence: an accepted item with a zero term goes straight to the output
//   register; otherwise it runs the normalize shifts, the binary GCD steps,
//   three divisions and the log loop before it enters the output register.
// Flow: one item in flight; the next can be taken the cycle after the result
//   enters the output register.
// Reset: synchronous, active low; clears the controller and output valid.
// ----------------------------------------------------------------------------
// pitch_ratio_normalizer_unit: octave-reduced fraction with log2
// Folds a frequency ratio into [1,2) while tracking octaves, reduces it to
// lowest terms and gives log2 of it as a truncated Q0.16 fraction.
// ----------------------------------------------------------------------------
module pitch_ratio_normalizer_unit import prn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] ratio_top, [31:16] ratio_bottom, [41:32] octave_offset, rest 0
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // result item stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] reduced_top, [63:32] reduced_bottom, [74:64] octave_count,
    // [90:75] log_pitch, [91] is_null, rest 0
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_cmd    w_cmd;
    t_status w_stat;

    // Controller: one item at a time. Idle accepts, then normalize
    // (shift num up, then den up), binary GCD, num/g, den/g, then the
    // Q1.31 quotient for the log and one squaring per log bit.
    prn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // Datapath: all arithmetic, plus the output register that holds a
    // finished item while the next one is being worked on.
    prn_dpath u_dpath (
        .i_clk      (i_clk),
        .i_in_data  (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (m_axis_tdata)
    );

endmodule

// ----- hw/rtl/prn_ctrl.sv -----
// ----------------------------------------------------------------------------
// prn_ctrl: pitch ratio normalizer controller
// Sequences normalize, GCD, three divisions and the squaring log loop.
// ----------------------------------------------------------------------------
module prn_ctrl import prn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_stat,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_BITS - 1);
    localparam logic [CNT_W-1:0] LOG_LAST = CNT_W'(LOG_FRAC_BITS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ovalid   = r_ovalid;
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = i_stat.in_null ? ST_FIN : ST_NORM_UP;
                end
            end
            ST_NORM_UP: begin
                if (i_stat.num_lt) begin
                    o_cmd = CMD_NORM_UP;
                end else begin
                    n_state = ST_NORM_DN;
                end
            end
            ST_NORM_DN: begin
                if (i_stat.num_ge2) begin
                    o_cmd = CMD_NORM_DN;
                end else begin
                    o_cmd   = CMD_GCD_LOAD;
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (i_stat.gcd_eq) begin
                    o_cmd   = CMD_DIV_N_START;
                    n_cnt   = '0;
                    n_state = ST_DIV_N;
                end else begin
                    o_cmd = CMD_GCD_STEP;
                end
            end
            ST_DIV_N: begin
                o_cmd = CMD_DIV_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_START_D;
                end
            end
            ST_START_D: begin
                o_cmd   = CMD_DIV_D_START;
                n_cnt   = '0;
                n_state = ST_DIV_D;
            end
            ST_DIV_D: begin
                o_cmd = CMD_DIV_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_START_L;
                end
            end
            ST_START_L: begin
                o_cmd   = CMD_DIV_L_START;
                n_cnt   = '0;
                n_state = ST_DIV_L;
            end
            ST_DIV_L: begin
                o_cmd = CMD_DIV_STEP;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_LOG_INIT;
                end
            end
            ST_LOG_INIT: begin
                o_cmd   = CMD_LOG_INIT;
                n_cnt   = '0;
                n_state = ST_LOG_SQ;
            end
            ST_LOG_SQ: begin
                o_cmd   = CMD_LOG_MUL;
                n_state = ST_LOG_UPD;
            end
            ST_LOG_UPD: begin
                o_cmd = CMD_LOG_UPD;
                n_cnt = r_cnt + 1'b1;
                n_state = (r_cnt == LOG_LAST) ? ST_FIN : ST_LOG_SQ;
            end
            ST_FIN: begin
                // wait for the output register to be free
                if (!r_ovalid || i_out_ready) begin
                    o_cmd    = CMD_OUT_LOAD;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

// ----- hw/rtl/prn_dpath.sv -----
// ----------------------------------------------------------------------------
// prn_dpath: pitch ratio normalizer datapath
// Term registers, binary GCD, shared restoring divider, log squarer, output.
// ----------------------------------------------------------------------------
module prn_dpath import prn_pkg::*; (
    input  logic                 i_clk,
    input  logic [S_TDATA_W-1:0] i_in_data,
    input  t_cmd                 i_cmd,
    output t_status              o_stat,
    output logic [M_TDATA_W-1:0] o_out_data
);

    // normalized terms and octave
    logic [WORK_W-1:0] r_num, r_den;
    logic [OCT_W-1:0]  r_oct;
    logic              r_null;
    // GCD
    logic [WORK_W-1:0] r_ga, r_gb;
    logic [K_W-1:0]    r_gk;
    // divider
    logic [WORK_W-1:0]   r_rem, r_dvs;
    logic [DIV_BITS-1:0] r_dsh, r_quo;
    // reduced pair
    logic [WORK_W-1:0] r_red_top, r_red_bot;
    // log
    logic [Y_W-1:0]    r_y;
    logic [PROD_W-1:0] r_prod;
    logic [LOGB_W-1:0] r_bits;
    // output register
    logic [M_TDATA_W-1:0] r_out;

    logic [IN_W-1:0]   w_in_top, w_in_bot;
    logic [OCT_W-1:0]  w_in_oct;
    logic [WORK_W:0]   w_rem2, w_rem_sub;
    logic              w_qbit;
    logic [WORK_W-1:0] w_g;
    logic [PROD_W-1:0] w_sq;

    assign w_in_top = i_in_data[IN_W-1:0];
    assign w_in_bot = i_in_data[TOP_IN_W +: IN_W];
    assign w_in_oct = {i_in_data[TOP_IN_W+BOT_IN_W+OCT_IN_W-1],
                       i_in_data[TOP_IN_W+BOT_IN_W +: OCT_IN_W]};

    assign o_stat.in_null = (w_in_top == '0) || (w_in_bot == '0);
    assign o_stat.num_lt  = r_num < r_den;
    assign o_stat.num_ge2 = {1'b0, r_num} >= {r_den, 1'b0};
    assign o_stat.gcd_eq  = r_ga == r_gb;

    // restoring divide step
    assign w_rem2    = {r_rem, r_dsh[DIV_BITS-1]};
    assign w_rem_sub = w_rem2 - {1'b0, r_dvs};
    assign w_qbit    = w_rem2 >= {1'b0, r_dvs};

    assign w_g  = r_ga << r_gk;
    assign w_sq = r_y * r_y;

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_num  <= WORK_W'(w_in_top);
                r_den  <= WORK_W'(w_in_bot);
                r_oct  <= w_in_oct;
                r_null <= o_stat.in_null;
            end
            CMD_NORM_UP: begin
                r_num <= r_num << 1;
                r_oct <= r_oct - 1'b1;
            end
            CMD_NORM_DN: begin
                r_den <= r_den << 1;
                r_oct <= r_oct + 1'b1;
            end
            CMD_GCD_LOAD: begin
                r_ga <= r_num;
                r_gb <= r_den;
                r_gk <= '0;
            end
            CMD_GCD_STEP: begin
                if (!r_ga[0] && !r_gb[0]) begin
                    r_ga <= r_ga >> 1;
                    r_gb <= r_gb >> 1;
                    r_gk <= r_gk + 1'b1;
                end else if (!r_ga[0]) begin
                    r_ga <= r_ga >> 1;
                end else if (!r_gb[0]) begin
                    r_gb <= r_gb >> 1;
                end else if (r_ga > r_gb) begin
                    r_ga <= r_ga - r_gb;
                end else begin
                    r_gb <= r_gb - r_ga;
                end
            end
            CMD_DIV_N_START: begin
                r_dvs <= w_g;
                r_rem <= '0;
                r_dsh <= DIV_BITS'(r_num);
            end
            CMD_DIV_STEP: begin
                r_rem <= w_qbit ? w_rem_sub[WORK_W-1:0] : w_rem2[WORK_W-1:0];
                r_dsh <= r_dsh << 1;
                r_quo <= {r_quo[DIV_BITS-2:0], w_qbit};
            end
            CMD_DIV_D_START: begin
                r_red_top <= r_quo[WORK_W-1:0];
                r_rem     <= '0;
                r_dsh     <= DIV_BITS'(r_den);
            end
            CMD_DIV_L_START: begin
                // num * 2^31 / den: high part num >> 1, then num[0] and zeros
                r_red_bot <= r_quo[WORK_W-1:0];
                r_dvs     <= r_den;
                r_rem     <= r_num >> 1;
                r_dsh     <= {r_num[0], {(DIV_BITS-1){1'b0}}};
            end
            CMD_LOG_INIT: begin
                r_y    <= r_quo;
                r_bits <= '0;
            end
            CMD_LOG_MUL: begin
                r_prod <= w_sq;
            end
            CMD_LOG_UPD: begin
                // y*y >> 31 reaching 2 sets the bit and halves
                if (r_prod[PROD_W-1]) begin
                    r_y    <= r_prod[PROD_W-1 -: Y_W];
                    r_bits <= {r_bits[LOGB_W-2:0], 1'b1};
                end else begin
                    r_y    <= r_prod[PROD_W-2 -: Y_W];
                    r_bits <= {r_bits[LOGB_W-2:0], 1'b0};
                end
            end
            CMD_OUT_LOAD: begin
                if (r_null) begin
                    r_out <= {{(M_TDATA_W-RED_W-RED_W-OCT_W-LOG_W-1){1'b0}},
                              1'b1, {(RED_W+RED_W+OCT_W+LOG_W){1'b0}}};
                end else begin
                    r_out <= {{(M_TDATA_W-RED_W-RED_W-OCT_W-LOG_W-1){1'b0}},
                              1'b0, r_bits[LOG_W-1:0], r_oct,
                              RED_W'(r_red_bot), RED_W'(r_red_top)};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_data = r_out;

endmodule
